// ===== rtl/ple_pkg.sv =====
`timescale 1ns / 1ps
// ple_pkg: shared constants, operation codes, state codes and the cell command
// struct of the positional list engine. no dependencies.
package ple_pkg;

  localparam int CAPACITY = 64;
  localparam int ELEM_W   = 32;
  localparam int MODE_W   = 2;
  localparam int POS_W    = 7;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int GRP      = 8;
  localparam int GRP_W    = $clog2(GRP);
  localparam int NGRP     = (CAPACITY + GRP - 1) / GRP;

  typedef enum logic [MODE_W-1:0] {
    MODE_INS = 2'd0,
    MODE_DEL = 2'd1,
    MODE_LOC = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WORK,
    ST_FINISH
  } state_e;

  // broadcast to every cell of the chain
  typedef struct packed {
    logic              do_ins;
    logic              do_del;
    logic [IDX_W-1:0]  pos_idx;
    logic [ELEM_W-1:0] value;
    logic [CNT_W-1:0]  count;
  } ple_cmd_t;

endpackage

// ===== rtl/ple_cell.sv =====
`timescale 1ns / 1ps
// ple_cell: one list slot; shifts with its neighbors on insert and delete,
// compares against the search word. depends on ple_pkg.
module ple_cell (
  input  logic                       clk_i,
  input  logic [ple_pkg::IDX_W-1:0]  idx_i,
  input  ple_pkg::ple_cmd_t          cmd_i,
  input  logic [ple_pkg::ELEM_W-1:0] left_i,
  input  logic [ple_pkg::ELEM_W-1:0] right_i,
  output logic [ple_pkg::ELEM_W-1:0] data_o,
  output logic                       match_o,
  output logic [ple_pkg::ELEM_W-1:0] pick_o
);
  import ple_pkg::*;

  logic [ELEM_W-1:0] data_q, data_d;
  logic              in_list;
  logic              is_pos;

  assign in_list = CNT_W'(idx_i) < cmd_i.count;
  assign is_pos  = idx_i == cmd_i.pos_idx;

  always_comb begin
    data_d = data_q;
    if (cmd_i.do_ins) begin
      if (is_pos) begin
        data_d = cmd_i.value;
      end else if ((idx_i > cmd_i.pos_idx) && (CNT_W'(idx_i) <= cmd_i.count)) begin
        data_d = left_i;
      end
    end else if (cmd_i.do_del) begin
      if ((idx_i >= cmd_i.pos_idx) &&
          (((CNT_W + 1)'(idx_i) + (CNT_W + 1)'(1)) < {1'b0, cmd_i.count})) begin
        data_d = right_i;
      end
    end
  end

  // stored list word
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o  = data_q;
  assign match_o = in_list && (data_q == cmd_i.value);
  assign pick_o  = is_pos ? data_q : '0;

endmodule

// ===== rtl/positional_list_engine.sv =====
`timescale 1ns / 1ps
// positional_list_engine: top level; an ordered list held in a chain of cells.
// depends on ple_pkg and ple_cell.

// The block holds an ordered list of up to CAPACITY 32-bit words in a row of
// cells. Each input word carries a mode: insert at a 1-based position (later
// entries move up), delete at a position (later entries move down, the removed
// word is returned) or locate the first entry equal to a value (its 1-based
// position is returned, 0 when absent). Insert into a full list, insert outside
// 1..length+1 and delete outside 1..length are refused with ok low and the list
// left as it was; mode 3 does nothing. Every input word gives exactly one result
// word carrying the list length after the operation. One word is handled at a
// time: in the work state every cell compares and shifts at once while the
// per-group hits of eight cells are registered, and in the finish state the
// groups are merged into the output register. A result word the consumer has
// not yet taken holds the block in the finish state. The next word is accepted
// in the idle state that follows the load of the result into the output
// register, so no new word is taken while one is still being handled. Cell
// contents are undefined after reset; only the length counter, the state and
// the output valid flag are cleared.
module positional_list_engine (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [ple_pkg::MODE_W-1:0]  mode_i,
  input  logic [ple_pkg::POS_W-1:0]   position_i,
  input  logic signed [ple_pkg::ELEM_W-1:0] value_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        ok_o,
  output logic signed [ple_pkg::ELEM_W-1:0] removed_value_o,
  output logic [ple_pkg::POS_W-1:0]   found_position_o,
  output logic [ple_pkg::POS_W-1:0]   list_length_o
);
  import ple_pkg::*;

  localparam int CMP_W = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

  // control state
  state_e            state_q, state_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              out_valid_q, out_valid_d;

  // latched request
  logic [MODE_W-1:0] mode_q;
  logic [POS_W-1:0]  pos_q;
  logic [ELEM_W-1:0] val_q;

  // per-group results captured in the work cycle
  logic [NGRP-1:0]   grp_hit_q;
  logic [GRP_W-1:0]  grp_off_q  [NGRP];
  logic [ELEM_W-1:0] grp_data_q [NGRP];
  logic [NGRP-1:0]   grp_hit_d;
  logic [GRP_W-1:0]  grp_off_d  [NGRP];
  logic [ELEM_W-1:0] grp_data_d [NGRP];
  logic              ins_ok_q, del_ok_q;

  // output register
  logic              ok_q;
  logic [ELEM_W-1:0] removed_q;
  logic [POS_W-1:0]  found_q;
  logic [POS_W-1:0]  length_q;

  // chain wiring
  ple_cmd_t          cmd;
  logic [ELEM_W-1:0] cell_data [CAPACITY];
  logic [ELEM_W-1:0] cell_pick [CAPACITY];
  logic [CAPACITY-1:0] cell_match;

  logic [CMP_W-1:0]  pos_ext, cnt_ext;
  logic              ins_ok, del_ok;
  logic              in_acc, out_load;

  // finish-cycle merge
  logic              any_hit;
  logic [CNT_W-1:0]  hit_pos;
  logic [ELEM_W-1:0] picked;

  assign in_acc  = in_valid_i && in_ready_o;
  assign pos_ext = CMP_W'(pos_q);
  assign cnt_ext = CMP_W'(count_q);

  // range checks against the length before the operation
  assign ins_ok = (mode_q == MODE_INS) && (cnt_ext < CMP_W'(CAPACITY)) &&
                  (pos_ext >= CMP_W'(1)) && (pos_ext <= cnt_ext + CMP_W'(1));
  assign del_ok = (mode_q == MODE_DEL) && (pos_ext >= CMP_W'(1)) &&
                  (pos_ext <= cnt_ext);

  // the cells only move in the work cycle
  always_comb begin
    cmd.do_ins  = (state_q == ST_WORK) && ins_ok;
    cmd.do_del  = (state_q == ST_WORK) && del_ok;
    cmd.pos_idx = IDX_W'(pos_q - POS_W'(1));
    cmd.value   = val_q;
    cmd.count   = count_q;
  end

  // the chain: each cell sees its lower and upper neighbor
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [ELEM_W-1:0] left, right;
    if (i == 0) begin : g_first
      assign left = '0;
    end else begin : g_left
      assign left = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right = '0;
    end else begin : g_right
      assign right = cell_data[i+1];
    end
    ple_cell u_cell (
      .clk_i   (clk_i),
      .idx_i   (IDX_W'(i)),
      .cmd_i   (cmd),
      .left_i  (left),
      .right_i (right),
      .data_o  (cell_data[i]),
      .match_o (cell_match[i]),
      .pick_o  (cell_pick[i])
    );
  end

  // first hit and picked word inside each group of eight cells
  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_hit_d[g]  = 1'b0;
      grp_off_d[g]  = '0;
      grp_data_d[g] = '0;
      for (int j = GRP - 1; j >= 0; j--) begin
        if (g * GRP + j < CAPACITY) begin
          if (cell_match[g * GRP + j]) begin
            grp_hit_d[g] = 1'b1;
            grp_off_d[g] = GRP_W'(j);
          end
          grp_data_d[g] = grp_data_d[g] | cell_pick[g * GRP + j];
        end
      end
    end
  end

  // merge the groups, lowest group wins
  always_comb begin
    any_hit = 1'b0;
    hit_pos = '0;
    picked  = '0;
    for (int g = NGRP - 1; g >= 0; g--) begin
      if (grp_hit_q[g]) begin
        any_hit = 1'b1;
        hit_pos = CNT_W'(g * GRP) + CNT_W'(grp_off_q[g]) + CNT_W'(1);
      end
    end
    for (int g = 0; g < NGRP; g++) begin
      picked = picked | grp_data_q[g];
    end
  end

  // sequencer: latch, work, finish
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    out_valid_d = out_valid_q;
    out_load    = 1'b0;
    in_ready_o  = 1'b0;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d = ST_WORK;
        end
      end
      ST_WORK: begin
        if (ins_ok) begin
          count_d = count_q + CNT_W'(1);
        end else if (del_ok) begin
          count_d = count_q - CNT_W'(1);
        end
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        // wait for room in the output register
        if (!out_valid_q || out_ready_i) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // request latch
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      mode_q <= mode_i;
      pos_q  <= position_i;
      val_q  <= value_i;
    end
  end

  // group capture, before the cells shift
  always_ff @(posedge clk_i) begin
    if (state_q == ST_WORK) begin
      grp_hit_q <= grp_hit_d;
      grp_off_q <= grp_off_d;
      grp_data_q <= grp_data_d;
      ins_ok_q  <= ins_ok;
      del_ok_q  <= del_ok;
    end
  end

  // result word
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      ok_q      <= ins_ok_q || del_ok_q || ((mode_q == MODE_LOC) && any_hit);
      removed_q <= del_ok_q ? picked : '0;
      found_q   <= ((mode_q == MODE_LOC) && any_hit) ? POS_W'(hit_pos) : '0;
      length_q  <= POS_W'(count_q);
    end
  end

  assign out_valid_o      = out_valid_q;
  assign ok_o             = ok_q;
  assign removed_value_o  = removed_q;
  assign found_position_o = found_q;
  assign list_length_o    = length_q;

  // checks
  a_count_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    CMP_W'(count_q) <= CMP_W'(CAPACITY))
    else $error("list length above capacity");

  a_accept_work : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == ST_WORK))
    else $error("accepted word did not start work");

  a_work_finish : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WORK) |=> (state_q == ST_FINISH))
    else $error("work cycle not followed by finish");

  a_found_ok : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (found_position_o != '0)) |-> ok_o)
    else $error("found position without ok");

endmodule
